FILE: hw/rtl/keypad_code_lock_assert.svh
// Assertion macros shared by the keypad code lock RTL.
// Defining ASSERT_OFF compiles every check away to nothing.
`ifndef KEYPAD_CODE_LOCK_ASSERT_SVH
`define KEYPAD_CODE_LOCK_ASSERT_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define KCL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("keypad code lock check failed");
// The consequent must hold in the cycle after the antecedent.
`define KCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("keypad code lock check failed");
`else
`define KCL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/kcl_pkg.sv
// Shared types, register indexes and constants of the keypad code lock.
// Used by kcl_engine and keypad_code_lock; depends on nothing else.
package kcl_pkg;

	// Default geometry of the secret code.
	localparam int unsigned CODE_LENGTH_DEF = 5;
	localparam int unsigned DIGIT_BITS_DEF  = 4;

	// Widths fixed by the interface.
	localparam int unsigned TIME_W    = 16;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned KEY_W     = 4;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_LOCK_ENABLE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SECRET_CODE  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LONG_BLINK   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SHORT_BLINK  = 3'd5;

	// Reset values of the timing registers.
	localparam logic [TIME_W-1:0] DEBOUNCE_RST    = 16'd5000;
	localparam logic [TIME_W-1:0] TIMEOUT_RST     = 16'd5000;
	localparam logic [TIME_W-1:0] LONG_BLINK_RST  = 16'd2000;
	localparam logic [TIME_W-1:0] SHORT_BLINK_RST = 16'd200;

	// LED toggle counts: two per blink.
	localparam logic [2:0] TOGGLES_CORRECT = 3'd2;
	localparam logic [2:0] TOGGLES_WRONG   = 3'd6;
	localparam logic [2:0] TOGGLES_TIMEOUT = 3'd4;

	// Outcome reported on the tick that decides an entry.
	typedef enum logic [1:0] {
		VERDICT_NONE    = 2'd0,
		VERDICT_CORRECT = 2'd1,
		VERDICT_WRONG   = 2'd2,
		VERDICT_TIMEOUT = 2'd3
	} verdict_t;

	// Timing and enable registers seen by the engine.
	typedef struct packed {
		logic              lock_enable;
		logic [TIME_W-1:0] debounce_ticks;
		logic [TIME_W-1:0] timeout_ticks;
		logic [TIME_W-1:0] long_blink_ticks;
		logic [TIME_W-1:0] short_blink_ticks;
	} cfg_t;

	// One result transaction.
	typedef struct packed {
		logic       led_level;
		logic       keys_enabled;
		logic [1:0] lock_state;
		logic [2:0] digits_entered;
		logic       key_taken;
		verdict_t   verdict;
	} res_t;

	// Reset code: every digit equal to one, first digit in the lowest bits.
	function automatic logic [63:0] secret_reset_val(input int unsigned len,
	                                                 input int unsigned bits);
		logic [63:0] v;
		v = '0;
		for (int unsigned i = 0; i < len; i++) begin
			v[i*bits] = 1'b1;
		end
		return v;
	endfunction

endpackage

FILE: hw/rtl/kcl_engine.sv
// Lock state, digit store, timers and blink sequencer of the keypad code lock.
// Depends on kcl_pkg and the assertion macros in keypad_code_lock_assert.svh.
`include "keypad_code_lock_assert.svh"

module kcl_engine #(
	parameter int unsigned CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF,
	parameter int unsigned DIGIT_BITS  = kcl_pkg::DIGIT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic                            cmd,
	input  logic [kcl_pkg::KEY_W-1:0]       key_digit,
	input  kcl_pkg::cfg_t                   cfg,
	input  logic [CODE_LENGTH*DIGIT_BITS-1:0] secret_code,
	output kcl_pkg::res_t                   res
);

	localparam int unsigned CNT_W = $clog2(CODE_LENGTH + 1);
	localparam int unsigned TW    = kcl_pkg::TIME_W;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WAIT  = 2'd1,
		PH_CHECK = 2'd2
	} phase_t;

	phase_t                phase_q, phase_n;
	logic [DIGIT_BITS-1:0] digits_q [CODE_LENGTH];
	logic [CNT_W-1:0]      count_q, count_n;
	logic [TW-1:0]         deb_q, deb_n;
	logic [TW-1:0]         idle_q, idle_n;
	logic                  keys_open_q, keys_open_n;
	logic [2:0]            tog_q, tog_n;
	logic [TW-1:0]         bw_q, bw_n;
	logic [TW-1:0]         period_q, period_n;
	logic                  led_q, led_n;
	logic                  store, clear, taken, match;
	kcl_pkg::verdict_t     verdict;
	logic [DIGIT_BITS-1:0] digit_w;

	// Key value cut or widened to the digit width.
	assign digit_w = DIGIT_BITS'({8'd0, key_digit});

	// Compare all stored digits with the secret code at once.
	always_comb begin
		match = 1'b1;
		for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
			if (digits_q[i] != secret_code[i*DIGIT_BITS +: DIGIT_BITS]) begin
				match = 1'b0;
			end
		end
	end

	// Next state for one transaction.
	always_comb begin
		phase_n     = phase_q;
		count_n     = count_q;
		deb_n       = deb_q;
		idle_n      = idle_q;
		keys_open_n = keys_open_q;
		tog_n       = tog_q;
		bw_n        = bw_q;
		period_n    = period_q;
		led_n       = led_q;
		store       = 1'b0;
		clear       = 1'b0;
		taken       = 1'b0;
		verdict     = kcl_pkg::VERDICT_NONE;
		if (cfg.lock_enable) begin
			if (cmd) begin
				// A key counts only with the keypad open and no debounce pending.
				if (deb_q == '0 && keys_open_q) begin
					taken       = 1'b1;
					keys_open_n = 1'b0;
					deb_n       = (cfg.debounce_ticks != '0) ? cfg.debounce_ticks : TW'(1);
					idle_n      = '0;
					if (count_q < CNT_W'(CODE_LENGTH)) begin
						store   = 1'b1;
						count_n = count_q + CNT_W'(1);
					end
				end
			end else begin
				case (phase_q)
					PH_IDLE: begin
						if (tog_q != '0) begin
							if (bw_q != '0) begin
								bw_n = bw_q - TW'(1);
							end else begin
								led_n = ~led_q;
								tog_n = tog_q - 3'd1;
								bw_n  = period_q;
							end
						end else begin
							// Blinking done: start a fresh entry.
							phase_n     = PH_WAIT;
							count_n     = '0;
							deb_n       = '0;
							idle_n      = '0;
							bw_n        = '0;
							period_n    = '0;
							clear       = 1'b1;
							keys_open_n = 1'b1;
						end
					end
					PH_WAIT: begin
						if (deb_q > TW'(1)) begin
							deb_n = deb_q - TW'(1);
						end else if (deb_q == TW'(1)) begin
							deb_n       = '0;
							keys_open_n = 1'b1;
						end else if (idle_q >= cfg.timeout_ticks) begin
							period_n = cfg.short_blink_ticks;
							tog_n    = kcl_pkg::TOGGLES_TIMEOUT;
							phase_n  = PH_IDLE;
							verdict  = kcl_pkg::VERDICT_TIMEOUT;
						end else if (count_q >= CNT_W'(CODE_LENGTH)) begin
							phase_n = PH_CHECK;
						end
						// The inactivity counter saturates.
						if (idle_q != '1) begin
							idle_n = idle_q + TW'(1);
						end
					end
					PH_CHECK: begin
						if (match) begin
							period_n = cfg.long_blink_ticks;
							tog_n    = kcl_pkg::TOGGLES_CORRECT;
							verdict  = kcl_pkg::VERDICT_CORRECT;
						end else begin
							period_n = cfg.short_blink_ticks;
							tog_n    = kcl_pkg::TOGGLES_WRONG;
							verdict  = kcl_pkg::VERDICT_WRONG;
						end
						phase_n = PH_IDLE;
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase
			end
		end
	end

	// Result fields show the state after this transaction.
	always_comb begin
		res.led_level      = led_n;
		res.keys_enabled   = keys_open_n;
		res.lock_state     = phase_n;
		res.digits_entered = 3'(count_n);
		res.key_taken      = taken;
		res.verdict        = verdict;
	end

	// State registers, updated once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			deb_q       <= '0;
			idle_q      <= '0;
			keys_open_q <= 1'b1;
			tog_q       <= '0;
			bw_q        <= '0;
			period_q    <= '0;
			led_q       <= 1'b0;
			for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
				digits_q[i] <= '0;
			end
		end else if (step) begin
			phase_q     <= phase_n;
			count_q     <= count_n;
			deb_q       <= deb_n;
			idle_q      <= idle_n;
			keys_open_q <= keys_open_n;
			tog_q       <= tog_n;
			bw_q        <= bw_n;
			period_q    <= period_n;
			led_q       <= led_n;
			for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
				if (clear) begin
					digits_q[i] <= '0;
				end else if (store && count_q == CNT_W'(i)) begin
					digits_q[i] <= digit_w;
				end
			end
		end
	end

	// An accepted key closes the keypad and arms the debounce.
	`KCL_ASSERT_NEXT(a_key_closes, clk, arst_n, step && taken, !keys_open_q && deb_q != '0)
	// A decided entry always leaves blinks to play.
	`KCL_ASSERT_NEXT(a_verdict_blinks, clk, arst_n, step && verdict != kcl_pkg::VERDICT_NONE,
		phase_q == PH_IDLE && tog_q != '0)
	// Checking is reached only with a full digit store.
	`KCL_ASSERT_SAME(a_check_full, clk, arst_n, phase_q == PH_CHECK,
		count_q == CNT_W'(CODE_LENGTH))

endmodule

FILE: hw/rtl/keypad_code_lock.sv
// Keypad code lock top level: handshakes, configuration registers, engine.
// An accepted input transaction is registered in the input stage, then its result in the result stage.
// Throughput: one item per cycle while results are taken, set by the engine updating its state once per item.
// Input and result registers let a new item in while a result waits to be taken.
// Reset clears the lock to its blink phase with keys open and loads register defaults.
// Depends on kcl_pkg, kcl_engine and keypad_code_lock_assert.svh.
`include "keypad_code_lock_assert.svh"

module keypad_code_lock #(
	parameter int unsigned CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF,
	parameter int unsigned DIGIT_BITS  = kcl_pkg::DIGIT_BITS_DEF,
	parameter int unsigned CFG_W = (CODE_LENGTH * DIGIT_BITS > kcl_pkg::TIME_W) ?
		CODE_LENGTH * DIGIT_BITS : kcl_pkg::TIME_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [kcl_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          cmd,
	input  logic [kcl_pkg::KEY_W-1:0]     key_digit,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          led_level,
	output logic                          keys_enabled,
	output logic [1:0]                    lock_state,
	output logic [2:0]                    digits_entered,
	output logic                          key_taken,
	output logic [1:0]                    verdict
);

	localparam int unsigned CODE_W = CODE_LENGTH * DIGIT_BITS;
	localparam int unsigned TW     = kcl_pkg::TIME_W;

	kcl_pkg::cfg_t             cfg_q;
	logic [CODE_W-1:0]         secret_q;
	logic                      valid_s1;
	logic                      cmd_s1;
	logic [kcl_pkg::KEY_W-1:0] key_s1;
	logic                      valid_s2;
	kcl_pkg::res_t             res_s2;
	kcl_pkg::res_t             res_next;
	logic                      s2_free, advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lock_enable       <= 1'b0;
			cfg_q.debounce_ticks    <= kcl_pkg::DEBOUNCE_RST;
			cfg_q.timeout_ticks     <= kcl_pkg::TIMEOUT_RST;
			cfg_q.long_blink_ticks  <= kcl_pkg::LONG_BLINK_RST;
			cfg_q.short_blink_ticks <= kcl_pkg::SHORT_BLINK_RST;
			secret_q <= CODE_W'(kcl_pkg::secret_reset_val(CODE_LENGTH, DIGIT_BITS));
		end else if (cfg_wr_en) begin
			case (cfg_index)
				kcl_pkg::REG_LOCK_ENABLE: cfg_q.lock_enable       <= cfg_wdata[0];
				kcl_pkg::REG_SECRET_CODE: secret_q                <= cfg_wdata[CODE_W-1:0];
				kcl_pkg::REG_DEBOUNCE:    cfg_q.debounce_ticks    <= cfg_wdata[TW-1:0];
				kcl_pkg::REG_TIMEOUT:     cfg_q.timeout_ticks     <= cfg_wdata[TW-1:0];
				kcl_pkg::REG_LONG_BLINK:  cfg_q.long_blink_ticks  <= cfg_wdata[TW-1:0];
				kcl_pkg::REG_SHORT_BLINK: cfg_q.short_blink_ticks <= cfg_wdata[TW-1:0];
				default: ;
			endcase
		end
	end

	// Flow control between the input stage and the result stage.
	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			key_s1 <= key_digit;
		end
	end

	kcl_engine #(
		.CODE_LENGTH (CODE_LENGTH),
		.DIGIT_BITS  (DIGIT_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.cmd         (cmd_s1),
		.key_digit   (key_s1),
		.cfg         (cfg_q),
		.secret_code (secret_q),
		.res         (res_next)
	);

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid      = valid_s2;
	assign led_level      = res_s2.led_level;
	assign keys_enabled   = res_s2.keys_enabled;
	assign lock_state     = res_s2.lock_state;
	assign digits_entered = res_s2.digits_entered;
	assign key_taken      = res_s2.key_taken;
	assign verdict        = res_s2.verdict;

	// Input is refused only when both stages are full and the result is stalled.
	`KCL_ASSERT_SAME(a_ready_stall, clk, arst_n, !in_ready,
		valid_s1 && valid_s2 && !out_ready)
	// An item leaving the input stage always lands in the result stage.
	`KCL_ASSERT_NEXT(a_advance_lands, clk, arst_n, advance, valid_s2)
	// A result that is not taken is never dropped.
	`KCL_ASSERT_NEXT(a_result_held, clk, arst_n, valid_s2 && !out_ready, valid_s2)

endmodule

FILE: tb/keypad_code_lock_test.sv
// Self-checking testbench for the keypad code lock: directed entries, then random key and tick
// transactions. The results are compared against a cycle-free model of the lock.
// Depends on kcl_pkg and the keypad_code_lock RTL.
module keypad_code_lock_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CODE_LEN = kcl_pkg::CODE_LENGTH_DEF;
	localparam int DIGIT_W  = kcl_pkg::DIGIT_BITS_DEF;
	localparam int CFG_W    = CODE_LEN * DIGIT_W;

	// Transaction kinds on the input channel.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KEY  = 1'b1;

	// Lock phases as reported on lock_state.
	localparam logic [1:0] PH_BLINK = 2'd0;
	localparam logic [1:0] PH_WAIT  = 2'd1;
	localparam logic [1:0] PH_CHECK = 2'd2;

	localparam kcl_pkg::res_t RESET_OUT =
		'{1'b0, 1'b1, PH_BLINK, 3'd0, 1'b0, kcl_pkg::VERDICT_NONE};

	// One line of the directed plan: either a register write or an input transaction.
	typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;
	typedef struct packed {
		row_kind_t                     kind;
		logic [kcl_pkg::REG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]              wdata;
		logic                          is_key;
		logic [DIGIT_W-1:0]            digit;
		bit                            typed;
		kcl_pkg::res_t                 want;
	} row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [kcl_pkg::REG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]              cfg_wdata;
	logic                          in_valid;
	logic                          in_ready;
	logic                          cmd;
	logic [kcl_pkg::KEY_W-1:0]     key_digit;
	logic                          out_valid;
	logic                          out_ready;
	logic                          led_level;
	logic                          keys_enabled;
	logic [1:0]                    lock_state;
	logic [2:0]                    digits_entered;
	logic                          key_taken;
	logic [1:0]                    verdict;

	keypad_code_lock dut (.*);

	// Free-running 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Register copies and lock state of the prediction.
	logic                       lk_enable;
	logic [CFG_W-1:0]           lk_code;
	logic [kcl_pkg::TIME_W-1:0] lk_debounce, lk_timeout, lk_long, lk_short;
	logic [1:0]                 st_phase;
	logic [DIGIT_W-1:0]         st_digits [CODE_LEN];
	logic [2:0]                 st_count;
	logic [kcl_pkg::TIME_W-1:0] st_debounce_left, st_idle, st_blink_wait, st_blink_period;
	logic                       st_keys_open, st_led;
	logic [2:0]                 st_toggles;

	kcl_pkg::res_t pending_outcomes [$];
	int   fail_count = 0;
	bit   valid_up = 0;
	bit   write_up = 0;
	int   src_calm = 0;
	int   sink_calm = 0;

	// Advance the predicted lock by one transaction and return the outcome it reports.
	function automatic kcl_pkg::res_t advance_lock(input logic is_key,
	                                               input logic [DIGIT_W-1:0] d);
		kcl_pkg::res_t     r;
		logic              taken;
		kcl_pkg::verdict_t v;
		logic              match;
		taken = 1'b0;
		v = kcl_pkg::VERDICT_NONE;
		if (lk_enable) begin
			if (is_key) begin
				// A key gets in only with the keypad open and no debounce running.
				if (st_debounce_left == '0 && st_keys_open) begin
					taken = 1'b1;
					st_keys_open = 1'b0;
					st_debounce_left = (lk_debounce != '0) ? lk_debounce : 16'd1;
					st_idle = '0;
					if (st_count < CODE_LEN) begin
						st_digits[st_count] = d;
						st_count++;
					end
				end
			end else if (st_phase == PH_BLINK) begin
				if (st_toggles != '0) begin
					if (st_blink_wait != '0) begin
						st_blink_wait--;
					end else begin
						st_led = ~st_led;
						st_toggles--;
						st_blink_wait = st_blink_period;
					end
				end else begin
					// Blinking is over: clear the entry and open the keypad.
					st_phase = PH_WAIT;
					st_count = '0;
					st_debounce_left = '0;
					st_idle = '0;
					st_blink_wait = '0;
					st_blink_period = '0;
					foreach (st_digits[i]) st_digits[i] = '0;
					st_keys_open = 1'b1;
				end
			end else if (st_phase == PH_WAIT) begin
				if (st_debounce_left > 16'd1) begin
					st_debounce_left--;
				end else if (st_debounce_left == 16'd1) begin
					st_debounce_left = '0;
					st_keys_open = 1'b1;
				end else if (st_idle >= lk_timeout) begin
					st_blink_period = lk_short;
					st_toggles = kcl_pkg::TOGGLES_TIMEOUT;
					st_phase = PH_BLINK;
					v = kcl_pkg::VERDICT_TIMEOUT;
				end else if (st_count >= CODE_LEN) begin
					st_phase = PH_CHECK;
				end
				// The idle counter sticks at its top value.
				if (st_idle != 16'hFFFF) st_idle++;
			end else begin
				match = 1'b1;
				for (int i = 0; i < CODE_LEN; i++) begin
					if (st_digits[i] != lk_code[i*DIGIT_W +: DIGIT_W]) match = 1'b0;
				end
				if (match) begin
					st_blink_period = lk_long;
					st_toggles = kcl_pkg::TOGGLES_CORRECT;
					v = kcl_pkg::VERDICT_CORRECT;
				end else begin
					st_blink_period = lk_short;
					st_toggles = kcl_pkg::TOGGLES_WRONG;
					v = kcl_pkg::VERDICT_WRONG;
				end
				st_phase = PH_BLINK;
			end
		end
		r.led_level = st_led;
		r.keys_enabled = st_keys_open;
		r.lock_state = st_phase;
		r.digits_entered = st_count;
		r.key_taken = taken;
		r.verdict = v;
		return r;
	endfunction

	// Idle cycles before the next transaction on one side, with calm stretches of none.
	function automatic int pick_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	function automatic row_t item_row(input logic is_key, input logic [DIGIT_W-1:0] d);
		row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.is_key = is_key;
		r.digit = d;
		return r;
	endfunction

	function automatic row_t known_row(input logic is_key, input logic [DIGIT_W-1:0] d,
	                                   input kcl_pkg::res_t want);
		row_t r;
		r = item_row(is_key, d);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic row_t reg_row(input logic [kcl_pkg::REG_IDX_W-1:0] idx,
	                                 input logic [CFG_W-1:0] v);
		row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.wdata = v;
		return r;
	endfunction

	// Drop the write enable once a group of register writes is done.
	task automatic end_writes();
		if (write_up) begin
			cfg_wr_en <= 1'b0;
			write_up = 0;
		end
	endtask

	// Stop sending and wait until every predicted outcome has come back.
	task automatic settle();
		if (valid_up) begin
			in_valid <= 1'b0;
			valid_up = 0;
		end
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	// One register write; the prediction takes the new value at the same edge.
	task automatic write_reg(input logic [kcl_pkg::REG_IDX_W-1:0] idx,
	                         input logic [CFG_W-1:0] v);
		cfg_wr_en <= 1'b1;
		write_up = 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		case (idx)
			kcl_pkg::REG_LOCK_ENABLE: lk_enable = v[0];
			kcl_pkg::REG_SECRET_CODE: lk_code = v;
			kcl_pkg::REG_DEBOUNCE:    lk_debounce = v[kcl_pkg::TIME_W-1:0];
			kcl_pkg::REG_TIMEOUT:     lk_timeout = v[kcl_pkg::TIME_W-1:0];
			kcl_pkg::REG_LONG_BLINK:  lk_long = v[kcl_pkg::TIME_W-1:0];
			kcl_pkg::REG_SHORT_BLINK: lk_short = v[kcl_pkg::TIME_W-1:0];
			default: ;
		endcase
	endtask

	// Load every register of the lock while it is idle.
	task automatic set_config(input logic en, input logic [CFG_W-1:0] code,
	                          input int deb, input int tmo, input int lng, input int sht);
		settle();
		write_reg(kcl_pkg::REG_LOCK_ENABLE, CFG_W'(en));
		write_reg(kcl_pkg::REG_SECRET_CODE, code);
		write_reg(kcl_pkg::REG_DEBOUNCE, CFG_W'(deb));
		write_reg(kcl_pkg::REG_TIMEOUT, CFG_W'(tmo));
		write_reg(kcl_pkg::REG_LONG_BLINK, CFG_W'(lng));
		write_reg(kcl_pkg::REG_SHORT_BLINK, CFG_W'(sht));
		end_writes();
	endtask

	// Offer one input transaction and record its outcome once it is accepted.
	task automatic send_item(input logic is_key, input logic [DIGIT_W-1:0] d, input bit typed,
	                         input kcl_pkg::res_t want);
		int            gap;
		kcl_pkg::res_t outcome;
		gap = pick_gap(src_calm);
		end_writes();
		if (gap != 0) begin
			if (valid_up) in_valid <= 1'b0;
			valid_up = 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		valid_up = 1;
		cmd <= is_key;
		key_digit <= d;
		do @(posedge clk); while (in_ready !== 1'b1);
		outcome = advance_lock(is_key, d);
		pending_outcomes.push_back(typed ? want : outcome);
	endtask

	// Mostly well-formed entries: keys when the keypad is open, often the right digit.
	task automatic random_item();
		logic               is_key;
		logic [DIGIT_W-1:0] d;
		d = DIGIT_W'($urandom_range(0, 15));
		if (st_phase == PH_WAIT && st_keys_open && st_debounce_left == '0 &&
		    st_count < CODE_LEN && $urandom_range(0, 9) < 7) begin
			is_key = CMD_KEY;
			if ($urandom_range(0, 4) != 0) d = lk_code[st_count*DIGIT_W +: DIGIT_W];
		end else begin
			is_key = ($urandom_range(0, 9) == 0) ? CMD_KEY : CMD_TICK;
		end
		send_item(is_key, d, 1'b0, '0);
	endtask

	// Result side: random stalls of out_ready, one draw per result transaction.
	initial begin : result_sink
		int  gap;
		bit  ready_up;
		ready_up = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_gap(sink_calm);
			if (gap != 0) begin
				if (ready_up) out_ready <= 1'b0;
				ready_up = 0;
				repeat (gap) @(posedge clk);
			end
			if (!ready_up) out_ready <= 1'b1;
			ready_up = 1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Compare each accepted result with the oldest predicted outcome.
	always @(posedge clk) begin : check_results
		kcl_pkg::res_t got, want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			got.led_level = led_level;
			got.keys_enabled = keys_enabled;
			got.lock_state = lock_state;
			got.digits_entered = digits_entered;
			got.key_taken = key_taken;
			got.verdict = kcl_pkg::verdict_t'(verdict);
			if (pending_outcomes.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: result transaction with no outcome pending", $time);
			end else begin
				want = pending_outcomes.pop_front();
				if (got !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"%0t: outcome mismatch, expected led=%b keys=%b state=%0d ",
						          "digits=%0d taken=%b verdict=%0d, got led=%b keys=%b state=%0d ",
						          "digits=%0d taken=%b verdict=%0d"}, $time,
						         want.led_level, want.keys_enabled, want.lock_state,
						         want.digits_entered, want.key_taken, want.verdict,
						         got.led_level, got.keys_enabled, got.lock_state,
						         got.digits_entered, got.key_taken, got.verdict);
				end
			end
		end
	end

	// Hard stop if the run hangs.
	initial begin : watchdog
		#4_000_000;
		$display("keypad_code_lock verification failed");
		$finish;
	end

	// Main sequence: reset, directed plan, random phases, drain and verdict.
	initial begin : stimulus
		row_t plan [$];
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_TICK;
		key_digit <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= kcl_pkg::REG_LOCK_ENABLE;
		cfg_wdata <= '0;

		// Prediction starts from the reset state of the lock.
		lk_enable = 1'b0;
		lk_code = 20'h11111;
		lk_debounce = kcl_pkg::DEBOUNCE_RST;
		lk_timeout = kcl_pkg::TIMEOUT_RST;
		lk_long = kcl_pkg::LONG_BLINK_RST;
		lk_short = kcl_pkg::SHORT_BLINK_RST;
		st_phase = PH_BLINK;
		foreach (st_digits[i]) st_digits[i] = '0;
		st_count = '0;
		st_debounce_left = '0;
		st_idle = '0;
		st_keys_open = 1'b1;
		st_toggles = '0;
		st_blink_wait = '0;
		st_blink_period = '0;
		st_led = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed plan: disabled lock, a correct entry with a refused key, a zero timeout,
		// and a key during blinking.
		plan = '{
			known_row(CMD_TICK, 4'd0, RESET_OUT),
			known_row(CMD_KEY, 4'd15, RESET_OUT),
			reg_row(kcl_pkg::REG_DEBOUNCE, 20'd0),
			reg_row(kcl_pkg::REG_TIMEOUT, 20'd20),
			reg_row(kcl_pkg::REG_LONG_BLINK, 20'd0),
			reg_row(kcl_pkg::REG_SHORT_BLINK, 20'd0),
			reg_row(kcl_pkg::REG_SECRET_CODE, 20'hF0F0F),
			reg_row(kcl_pkg::REG_LOCK_ENABLE, 20'd1),
			known_row(CMD_TICK, 4'd0,
			          '{1'b0, 1'b1, PH_WAIT, 3'd0, 1'b0, kcl_pkg::VERDICT_NONE}),
			known_row(CMD_KEY, 4'd15,
			          '{1'b0, 1'b0, PH_WAIT, 3'd1, 1'b1, kcl_pkg::VERDICT_NONE}),
			known_row(CMD_KEY, 4'd0,
			          '{1'b0, 1'b0, PH_WAIT, 3'd1, 1'b0, kcl_pkg::VERDICT_NONE}),
			item_row(CMD_TICK, 4'd0), item_row(CMD_KEY, 4'd0),
			item_row(CMD_TICK, 4'd0), item_row(CMD_KEY, 4'd15),
			item_row(CMD_TICK, 4'd0), item_row(CMD_KEY, 4'd0),
			item_row(CMD_TICK, 4'd0), item_row(CMD_KEY, 4'd15),
			item_row(CMD_TICK, 4'd0), item_row(CMD_TICK, 4'd0), item_row(CMD_TICK, 4'd0),
			item_row(CMD_TICK, 4'd0), item_row(CMD_TICK, 4'd0), item_row(CMD_TICK, 4'd0),
			reg_row(kcl_pkg::REG_TIMEOUT, 20'd0),
			item_row(CMD_TICK, 4'd0), item_row(CMD_KEY, 4'd7),
			item_row(CMD_TICK, 4'd0), item_row(CMD_TICK, 4'd0), item_row(CMD_TICK, 4'd0),
			item_row(CMD_TICK, 4'd0), item_row(CMD_TICK, 4'd0)
		};
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[i].idx, plan[i].wdata);
			end else begin
				send_item(plan[i].is_key, plan[i].digit, plan[i].typed, plan[i].want);
			end
		end

		// Random phases with short timings so that entries run to a verdict.
		for (int p = 0; p < 6; p++) begin
			set_config(1'b1,
			           (p == 0) ? 20'h00000 : (p == 1) ? 20'hFFFFF : 20'($urandom()),
			           $urandom_range(0, 5), $urandom_range(0, 14),
			           $urandom_range(0, 6), $urandom_range(0, 6));
			repeat (210) random_item();
			if (p == 2) begin
				// A disabled stretch in the middle; the lock ignores all of it.
				set_config(1'b0, 20'($urandom()), 3, 5, 2, 2);
				repeat (30) random_item();
			end
		end

		// Largest debounce and blink waits.
		set_config(1'b1, 20'($urandom()), 16'hFFFF, 3, 16'hFFFF, 16'hFFFF);
		repeat (120) random_item();

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("keypad_code_lock verification clean");
		else
			$display("keypad_code_lock verification failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/kcl_pkg.sv
hw/rtl/kcl_engine.sv
hw/rtl/keypad_code_lock.sv
tb/keypad_code_lock_test.sv
